// ----- hw/rtl/ihc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ihc_pkg;

   localparam logic [3:0]  IPV4_VERSION        = 4'd4;
   localparam int unsigned HDR_BYTES_PER_WORD  = 4;
   localparam logic [7:0]  PROTO_UDP           = 8'd17;
   localparam logic [7:0]  PROTO_ICMP          = 8'd1;
   localparam logic [15:0] MIN_HEADER_BYTES    = 16'd20;
   localparam logic [15:0] CHECKSUM_GOOD       = 16'hFFFF;
   localparam logic [15:0] BYTE_COUNT_MAX      = 16'hFFFF;

   localparam logic [2:0] VERDICT_DELIVER      = 3'd0;
   localparam logic [2:0] VERDICT_UNREACHABLE  = 3'd1;
   localparam logic [2:0] VERDICT_SHORT        = 3'd2;
   localparam logic [2:0] VERDICT_BAD_VERSION  = 3'd3;
   localparam logic [2:0] VERDICT_BAD_LENGTH   = 3'd4;
   localparam logic [2:0] VERDICT_NOT_LOCAL    = 3'd5;
   localparam logic [2:0] VERDICT_BAD_CHECKSUM = 3'd6;

   localparam int unsigned QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  verdict;
      logic [7:0]  protocol_number;
      logic [31:0] source_address;
      logic [5:0]  header_bytes;
      logic [15:0] payload_bytes;
      logic [15:0] padding_bytes;
   } rsp_item_type;

   // per-packet summary handed from the byte front end to the verdict stage
   typedef struct packed {
      logic [15:0] rx_len;
      logic [7:0]  version_ihl;
      logic [15:0] total_length;
      logic [7:0]  proto;
      logic [31:0] source;
      logic [31:0] destination;
      logic [15:0] sum;
   } summary_type;

   typedef struct packed {
      logic        valid;
      summary_type summary;
   } summary_port_type;

endpackage

`default_nettype wire

// ----- hw/rtl/ipv4_receive_header_check_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// IPv4 receive header check. Packet bytes enter on req_ one per cycle while req_stall is low,
// header first in network order, with last set on the final byte. The front end captures
// the header fields and keeps a running ones' complement sum, and on the last byte posts a
// packet summary to a two-entry queue. The verdict stage turns each summary at the queue head
// into one rsp_ item (verdict, protocol, source, header and payload lengths, padding) held in
// an output register; the summary is registered in the queue before the result is. req_stall
// rises only while two summaries wait behind an unclaimed result. csr_ writes local_ip,
// compared with the destination; write it only between packets.
module ipv4_receive_header_check_unit #(
   parameter int MAX_PACKET_BYTES = 2048
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  ihc_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output ihc_pkg::rsp_item_type rsp_item,
   input  wire                   csr_write_enable,
   input  wire  [31:0]           csr_write_data
);
   import ihc_pkg::*;

   logic             accept;
   logic             queue_full;
   logic             pop;
   summary_port_type push;
   summary_port_type head;
   logic [31:0]      local_ip_ff, local_ip_in;

   assign req_stall   = queue_full;
   assign accept      = req_valid && !queue_full;
   assign local_ip_in = csr_write_enable ? csr_write_data : local_ip_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         local_ip_ff <= '0;
      end else begin
         local_ip_ff <= local_ip_in;
      end
   end

   ihc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_item (req_item),
      .push     (push)
   );

   ihc_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .pop   (pop),
      .head  (head)
   );

   ihc_back #(
      .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .local_ip  (local_ip_ff),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   a_lengths_only_on_pass: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.verdict != VERDICT_DELIVER
         && rsp_item.verdict != VERDICT_UNREACHABLE
      |-> rsp_item.payload_bytes == 16'd0 && rsp_item.padding_bytes == 16'd0)
      else $error("lengths reported for a rejected packet");

   a_deliver_known_proto: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.verdict == VERDICT_DELIVER
      |-> rsp_item.protocol_number == PROTO_UDP
         || rsp_item.protocol_number == PROTO_ICMP)
      else $error("delivered item with unhandled protocol");

   a_pop_moves_result: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid)
      else $error("summary popped but no result presented");

endmodule

`default_nettype wire

// ----- hw/rtl/ihc_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ihc_front (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       accept,
   input  ihc_pkg::req_item_type     req_item,
   output ihc_pkg::summary_port_type push
);
   import ihc_pkg::*;

   logic [15:0] cnt_ff, cnt_in, cnt_upd;
   logic [7:0]  vi_ff, vi_in, vi_upd;
   logic [15:0] tl_ff, tl_in, tl_upd;
   logic [7:0]  proto_ff, proto_in, proto_upd;
   logic [31:0] src_ff, src_in, src_upd;
   logic [31:0] dst_ff, dst_in, dst_upd;
   logic [15:0] sum_ff, sum_in, sum_upd;
   logic [7:0]  hi_ff, hi_in, hi_upd;
   logic [15:0] hdr_len;
   logic [16:0] raw_sum;
   logic [15:0] word;
   logic [7:0]  b;

   always_comb begin
      b         = req_item.data_byte;
      vi_upd    = vi_ff;
      tl_upd    = tl_ff;
      proto_upd = proto_ff;
      src_upd   = src_ff;
      dst_upd   = dst_ff;
      sum_upd   = sum_ff;
      hi_upd    = hi_ff;

      if (cnt_ff == 16'd0) begin
         vi_upd = b;
      end else if (cnt_ff == 16'd2) begin
         tl_upd = {b, tl_ff[7:0]};
      end else if (cnt_ff == 16'd3) begin
         tl_upd = {tl_ff[15:8], b};
      end else if (cnt_ff == 16'd9) begin
         proto_upd = b;
      end else if (cnt_ff >= 16'd12 && cnt_ff <= 16'd15) begin
         src_upd = {src_ff[23:0], b};
      end else if (cnt_ff >= 16'd16 && cnt_ff <= 16'd19) begin
         dst_upd = {dst_ff[23:0], b};
      end

      // ones' complement add with end-around carry
      word    = {hi_ff, b};
      raw_sum = {1'b0, sum_ff} + {1'b0, word};
      hdr_len = {10'd0, vi_upd[3:0], 2'b00};
      if (cnt_ff < hdr_len) begin
         if (!cnt_ff[0]) begin
            hi_upd = b;
         end else begin
            sum_upd = raw_sum[15:0] + {15'd0, raw_sum[16]};
         end
      end

      cnt_upd = (cnt_ff == BYTE_COUNT_MAX) ? cnt_ff : cnt_ff + 16'd1;

      push.valid                = accept && req_item.last;
      push.summary.rx_len       = cnt_upd;
      push.summary.version_ihl  = vi_upd;
      push.summary.total_length = tl_upd;
      push.summary.proto        = proto_upd;
      push.summary.source       = src_upd;
      push.summary.destination  = dst_upd;
      push.summary.sum          = sum_upd;

      cnt_in   = cnt_ff;
      vi_in    = vi_ff;
      tl_in    = tl_ff;
      proto_in = proto_ff;
      src_in   = src_ff;
      dst_in   = dst_ff;
      sum_in   = sum_ff;
      hi_in    = hi_ff;
      if (accept) begin
         if (req_item.last) begin
            cnt_in   = '0;
            vi_in    = '0;
            tl_in    = '0;
            proto_in = '0;
            src_in   = '0;
            dst_in   = '0;
            sum_in   = '0;
            hi_in    = '0;
         end else begin
            cnt_in   = cnt_upd;
            vi_in    = vi_upd;
            tl_in    = tl_upd;
            proto_in = proto_upd;
            src_in   = src_upd;
            dst_in   = dst_upd;
            sum_in   = sum_upd;
            hi_in    = hi_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         vi_ff    <= '0;
         tl_ff    <= '0;
         proto_ff <= '0;
         src_ff   <= '0;
         dst_ff   <= '0;
         sum_ff   <= '0;
         hi_ff    <= '0;
      end else begin
         cnt_ff   <= cnt_in;
         vi_ff    <= vi_in;
         tl_ff    <= tl_in;
         proto_ff <= proto_in;
         src_ff   <= src_in;
         dst_ff   <= dst_in;
         sum_ff   <= sum_in;
         hi_ff    <= hi_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/ihc_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ihc_queue (
   input  wire                       clock,
   input  wire                       reset,
   input  ihc_pkg::summary_port_type push,
   output logic                      full,
   input  wire                       pop,
   output ihc_pkg::summary_port_type head
);
   import ihc_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   summary_type      entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   always_comb begin
      full         = (count_ff == CNT_W'(QUEUE_DEPTH));
      head.valid   = (count_ff != '0);
      head.summary = entry_ff[rd_ptr_ff];
      do_push      = push.valid && !full;
      do_pop       = pop && head.valid;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.summary;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/ihc_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ihc_back #(
   parameter int MAX_PACKET_BYTES = 2048
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire  [31:0]               local_ip,
   input  ihc_pkg::summary_port_type head,
   output logic                      pop,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output ihc_pkg::rsp_item_type     rsp_item
);
   import ihc_pkg::*;

   summary_type  s;
   rsp_item_type item;
   logic [15:0]  hdr_len;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff;

   always_comb begin
      s       = head.summary;
      hdr_len = {10'd0, s.version_ihl[3:0], 2'b00};

      if (s.rx_len < MIN_HEADER_BYTES || s.rx_len < hdr_len) begin
         item.verdict = VERDICT_SHORT;
      end else if (s.version_ihl[7:4] != IPV4_VERSION) begin
         item.verdict = VERDICT_BAD_VERSION;
      end else if (s.total_length > s.rx_len || s.rx_len > 16'(MAX_PACKET_BYTES)) begin
         item.verdict = VERDICT_BAD_LENGTH;
      end else if (s.destination != local_ip) begin
         item.verdict = VERDICT_NOT_LOCAL;
      end else if (s.sum != CHECKSUM_GOOD) begin
         item.verdict = VERDICT_BAD_CHECKSUM;
      end else if (s.proto == PROTO_UDP || s.proto == PROTO_ICMP) begin
         item.verdict = VERDICT_DELIVER;
      end else begin
         item.verdict = VERDICT_UNREACHABLE;
      end

      item.protocol_number = s.proto;
      item.source_address  = s.source;
      item.header_bytes    = hdr_len[5:0];
      item.payload_bytes   = '0;
      item.padding_bytes   = '0;
      if (item.verdict == VERDICT_DELIVER || item.verdict == VERDICT_UNREACHABLE) begin
         item.payload_bytes = (s.total_length > hdr_len) ? s.total_length - hdr_len : '0;
         item.padding_bytes = s.rx_len - s.total_length;
      end

      pop          = head.valid && (!rsp_valid_ff || !rsp_stall);
      rsp_valid_in = pop || (rsp_valid_ff && rsp_stall);
      rsp_valid    = rsp_valid_ff;
      rsp_item     = rsp_item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_item_ff <= item;
      end
   end

endmodule

`default_nettype wire
